// File: design/smabs_pkg.sv
// shared types and constants for the moving average band signal block
package smabs_pkg;

    localparam int MAX_PERIOD = 32;
    localparam int PRICE_BITS = 32;
    localparam int SLOT_W     = $clog2(MAX_PERIOD);
    localparam int SEEN_W     = $clog2(MAX_PERIOD + 1);
    localparam int SUM_W      = PRICE_BITS + SLOT_W;
    localparam int BAND_W     = 16;
    localparam int FRAC_W     = 15;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_CNT_W  = $clog2(SUM_W);

    localparam logic [SEEN_W-1:0]     WIN_LEN_RESET   = SEEN_W'(5);
    localparam logic [BAND_W-1:0]     BAND_LOW_RESET  = BAND_W'(32440);
    localparam logic [BAND_W-1:0]     BAND_HIGH_RESET = BAND_W'(33096);
    localparam logic [DIV_CNT_W-1:0]  DIV_LAST        = DIV_CNT_W'(SUM_W - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH     = 2'd2;

    localparam logic [1:0] SIG_HOLD = 2'd0;
    localparam logic [1:0] SIG_BUY  = 2'd1;
    localparam logic [1:0] SIG_SELL = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV,
        ST_MUL,
        ST_CMP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic latch;
        logic update;
        logic div_step;
        logic mul;
        logic cmp;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic              full_after;
        logic [SEEN_W-1:0] seen;
    } t_sts;

endpackage

// File: design/sma_band_signal.sv
// top level of the moving average band crossover signal block
// an accepted word goes through update and done during warm-up, and through update, divide,
// multiply, compare and done once the window is full; a new word is taken only back in idle
// the divide is a restoring divider, one quotient bit per cycle over the 37-bit sum
// synchronous active-low reset restores the default window and bands and clears sum and totals
// the price ring needs no clearing pass; entries are read only after being written
module sma_band_signal
    import smabs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [PRICE_BITS-1:0] i_price,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [PRICE_BITS-1:0] o_average,
    output logic [1:0]            o_signal,
    output logic [CNT_W-1:0]      o_buy_total,
    output logic [CNT_W-1:0]      o_sell_total,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    smabs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    smabs_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_price      (i_price),
        .o_sts        (sts),
        .o_average    (o_average),
        .o_signal     (o_signal),
        .o_buy_total  (o_buy_total),
        .o_sell_total (o_sell_total)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input taken while an item is in flight");

    a_seen_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.seen <= SEEN_W'(MAX_PERIOD))
        else $error("seen count above window maximum");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_valid || i_ready))
        else $error("output word overwritten before it was taken");

    a_signal_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_signal == SIG_HOLD || o_signal == SIG_BUY || o_signal == SIG_SELL))
        else $error("reserved signal code on output");

endmodule

// File: design/smabs_ctrl.sv
// controller state machine: sequences update, divide, multiply, compare and output
module smabs_ctrl
    import smabs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_ready,
    input  t_sts i_sts,
    output logic o_ready,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;
    logic                 r_out_valid, n_out_valid;
    logic                 accept;
    logic                 out_free;

    assign accept   = i_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (accept) n_state = ST_UPDATE;
            ST_UPDATE: n_state = i_sts.full_after ? ST_DIV : ST_DONE;
            ST_DIV:    if (r_div_cnt == DIV_LAST) n_state = ST_MUL;
            ST_MUL:    n_state = ST_CMP;
            ST_CMP:    n_state = ST_DONE;
            ST_DONE:   if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.latch    = accept;
        o_cmd.update   = (r_state == ST_UPDATE);
        o_cmd.div_step = (r_state == ST_DIV);
        o_cmd.mul      = (r_state == ST_MUL);
        o_cmd.cmp      = (r_state == ST_CMP);
        o_cmd.load_out = (r_state == ST_DONE) && out_free;
    end

    always_comb begin
        n_div_cnt = (r_state == ST_DIV) ? r_div_cnt + 1'b1 : '0;
        priority if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_cnt   <= n_div_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;

endmodule

// File: design/smabs_dp.sv
// datapath: config registers, price ring, window sum, divider, band compare, totals
module smabs_dp
    import smabs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [PRICE_BITS-1:0] i_price,
    output t_sts                  o_sts,
    output logic [PRICE_BITS-1:0] o_average,
    output logic [1:0]            o_signal,
    output logic [CNT_W-1:0]      o_buy_total,
    output logic [CNT_W-1:0]      o_sell_total
);

    localparam int PROD_W = PRICE_BITS + BAND_W;

    logic [SEEN_W-1:0]     r_win_len;
    logic [BAND_W-1:0]     r_band_lo;
    logic [BAND_W-1:0]     r_band_hi;
    logic [PRICE_BITS-1:0] r_ring [MAX_PERIOD];
    logic [PRICE_BITS-1:0] r_old;
    logic [PRICE_BITS-1:0] r_price;
    logic [SUM_W-1:0]      r_sum;
    logic [SLOT_W-1:0]     r_slot;
    logic [SEEN_W-1:0]     r_seen;
    logic [SUM_W-1:0]      r_dq;
    logic [SEEN_W-1:0]     r_rem;
    logic [PROD_W-1:0]     r_prod_lo;
    logic [PROD_W-1:0]     r_prod_hi;
    logic [PRICE_BITS-1:0] r_res_avg;
    logic [1:0]            r_res_sig;
    logic [CNT_W-1:0]      r_buy;
    logic [CNT_W-1:0]      r_sell;
    logic [PRICE_BITS-1:0] r_out_avg;
    logic [1:0]            r_out_sig;
    logic [CNT_W-1:0]      r_out_buy;
    logic [CNT_W-1:0]      r_out_sell;

    logic [SEEN_W-1:0]     period;
    logic [SLOT_W-1:0]     rd_addr;
    logic                  full_before;
    logic [SUM_W-1:0]      sum_next;
    logic [SEEN_W-1:0]     seen_next;
    logic [SEEN_W:0]       rem_sh;
    logic                  q_bit;
    logic [SEEN_W-1:0]     rem_next;
    logic [PRICE_BITS-1:0] quot;
    logic [PROD_W-1:0]     scaled;
    logic                  is_buy;
    logic                  is_sell;

    always_comb begin
        priority if (r_win_len == '0) begin
            period = SEEN_W'(1);
        end else if (r_win_len > SEEN_W'(MAX_PERIOD)) begin
            period = SEEN_W'(MAX_PERIOD);
        end else begin
            period = r_win_len;
        end
    end

    assign rd_addr     = r_slot - period[SLOT_W-1:0];
    assign full_before = (r_seen >= period);
    assign sum_next    = r_sum - (full_before ? SUM_W'(r_old) : '0) + SUM_W'(r_price);
    assign seen_next   = (r_seen == SEEN_W'(MAX_PERIOD)) ? r_seen : r_seen + 1'b1;

    assign o_sts.full_after = (seen_next >= period);
    assign o_sts.seen       = r_seen;

    // restoring divide, one quotient bit per cycle
    assign rem_sh   = {r_rem, r_dq[SUM_W-1]};
    assign q_bit    = (rem_sh >= {1'b0, period});
    assign rem_next = q_bit ? SEEN_W'(rem_sh - {1'b0, period}) : rem_sh[SEEN_W-1:0];
    assign quot     = r_dq[PRICE_BITS-1:0];

    assign scaled  = {1'b0, r_price, FRAC_W'(0)};
    assign is_buy  = (scaled < r_prod_lo);
    assign is_sell = (scaled > r_prod_hi);

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_ring[r_slot] <= r_price;
        end
        r_old <= r_ring[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len <= WIN_LEN_RESET;
            r_band_lo <= BAND_LOW_RESET;
            r_band_hi <= BAND_HIGH_RESET;
            r_sum     <= '0;
            r_slot    <= '0;
            r_seen    <= '0;
            r_buy     <= '0;
            r_sell    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WINDOW_LENGTH: begin
                        r_win_len <= i_cfg_data[SEEN_W-1:0];
                        r_sum     <= '0;
                        r_slot    <= '0;
                        r_seen    <= '0;
                    end
                    CFG_BAND_LOW:  r_band_lo <= i_cfg_data[BAND_W-1:0];
                    CFG_BAND_HIGH: r_band_hi <= i_cfg_data[BAND_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.update) begin
                r_sum  <= sum_next;
                r_slot <= r_slot + 1'b1;
                r_seen <= seen_next;
            end
            if (i_cmd.cmp) begin
                if (is_buy && (r_buy != '1)) begin
                    r_buy <= r_buy + 1'b1;
                end
                if (!is_buy && is_sell && (r_sell != '1)) begin
                    r_sell <= r_sell + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_price <= i_price;
        end
        if (i_cmd.update) begin
            r_dq      <= sum_next;
            r_rem     <= '0;
            r_res_avg <= r_price;
            r_res_sig <= SIG_HOLD;
        end
        if (i_cmd.div_step) begin
            r_dq  <= {r_dq[SUM_W-2:0], q_bit};
            r_rem <= rem_next;
        end
        if (i_cmd.mul) begin
            r_prod_lo <= PROD_W'(quot * r_band_lo);
            r_prod_hi <= PROD_W'(quot * r_band_hi);
        end
        if (i_cmd.cmp) begin
            r_res_avg <= quot;
            priority if (is_buy) begin
                r_res_sig <= SIG_BUY;
            end else if (is_sell) begin
                r_res_sig <= SIG_SELL;
            end else begin
                r_res_sig <= SIG_HOLD;
            end
        end
        if (i_cmd.load_out) begin
            r_out_avg  <= r_res_avg;
            r_out_sig  <= r_res_sig;
            r_out_buy  <= r_buy;
            r_out_sell <= r_sell;
        end
    end

    assign o_average    = r_out_avg;
    assign o_signal     = r_out_sig;
    assign o_buy_total  = r_out_buy;
    assign o_sell_total = r_out_sell;

endmodule

// File: verif/sma_band_signal_tb.sv
// self-checking testbench for the moving average band crossover signal block
module sma_band_signal_tb
    import smabs_pkg::*;
();

    localparam int                   CYCLE_LIMIT = 500000;
    localparam int                   PHASES      = 20;
    localparam int                   PHASE_WORDS = 57;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

    typedef struct packed {
        logic [PRICE_BITS-1:0] average;
        logic [1:0]            signal;
        logic [CNT_W-1:0]      buys;
        logic [CNT_W-1:0]      sells;
    } t_signal_word;

    class sma_signal_book;
        logic [5:0]            win_len;
        logic [BAND_W-1:0]     band_lo;
        logic [BAND_W-1:0]     band_hi;
        logic [PRICE_BITS-1:0] ring [MAX_PERIOD];
        logic [63:0]           sum;
        int unsigned           slot;
        int unsigned           seen;
        logic [CNT_W-1:0]      buys;
        logic [CNT_W-1:0]      sells;
        t_signal_word          expected [$];
        int                    errors;
        int                    words_in;
        int                    holds_out;
        int                    buys_out;
        int                    sells_out;

        function new();
            win_len   = 6'd5;
            band_lo   = 16'd32440;
            band_hi   = 16'd33096;
            sum       = '0;
            slot      = 0;
            seen      = 0;
            buys      = '0;
            sells     = '0;
            errors    = 0;
            words_in  = 0;
            holds_out = 0;
            buys_out  = 0;
            sells_out = 0;
        endfunction

        function void note_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_WINDOW_LENGTH: begin
                    win_len = data[5:0];
                    sum     = '0;
                    slot    = 0;
                    seen    = 0;
                end
                CFG_BAND_LOW:  band_lo = data;
                CFG_BAND_HIGH: band_hi = data;
                default: ;
            endcase
        endfunction

        function void take_price(logic [PRICE_BITS-1:0] price);
            int unsigned  period;
            logic [63:0]  avg;
            logic [63:0]  scaled;
            t_signal_word want;
            period = (win_len == 0) ? 1 : ((win_len > MAX_PERIOD) ? MAX_PERIOD : win_len);
            // oldest price leaves once the window is full
            if (seen >= period)
                sum = sum - ring[(slot + MAX_PERIOD - period) % MAX_PERIOD];
            sum        = sum + price;
            ring[slot] = price;
            slot       = (slot + 1) % MAX_PERIOD;
            if (seen < MAX_PERIOD)
                seen++;
            avg         = {32'd0, price};
            want.signal = SIG_HOLD;
            if (seen >= period) begin
                scaled = {32'd0, price} << FRAC_W;
                avg    = sum / period;
                if (scaled < avg * band_lo) begin
                    want.signal = SIG_BUY;
                    if (buys != '1)
                        buys++;
                end else if (scaled > avg * band_hi) begin
                    want.signal = SIG_SELL;
                    if (sells != '1)
                        sells++;
                end
            end
            want.average = avg[PRICE_BITS-1:0];
            want.buys    = buys;
            want.sells   = sells;
            expected     = {expected, want};
            words_in++;
        endfunction

        function void match_signal(logic [PRICE_BITS-1:0] avg, logic [1:0] sig,
                                   logic [CNT_W-1:0] bt, logic [CNT_W-1:0] st);
            t_signal_word want;
            if (expected.size() == 0) begin
                errors++;
                $display("%0t unexpected word: average %0d signal %0d", $time, avg, sig);
                return;
            end
            want = expected.pop_front();
            if (avg !== want.average) begin
                errors++;
                $display("%0t average mismatch: expected %0d got %0d", $time, want.average, avg);
            end
            if (sig !== want.signal) begin
                errors++;
                $display("%0t signal mismatch: expected %0d got %0d", $time, want.signal, sig);
            end
            if (bt !== want.buys) begin
                errors++;
                $display("%0t buy total mismatch: expected %0d got %0d", $time, want.buys, bt);
            end
            if (st !== want.sells) begin
                errors++;
                $display("%0t sell total mismatch: expected %0d got %0d", $time, want.sells, st);
            end
            case (want.signal)
                SIG_BUY:  buys_out++;
                SIG_SELL: sells_out++;
                default:  holds_out++;
            endcase
        endfunction

        function int pending();
            return expected.size();
        endfunction
    endclass

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_valid    = 1'b0;
    logic [PRICE_BITS-1:0] i_price    = '0;
    logic                  i_ready    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_ready;
    logic                  o_valid;
    logic [PRICE_BITS-1:0] o_average;
    logic [1:0]            o_signal;
    logic [CNT_W-1:0]      o_buy_total;
    logic [CNT_W-1:0]      o_sell_total;

    sma_signal_book book = new();
    bit             idle_on = 1'b1;
    int             cycles = 0;
    int             settings = 1;

    sma_band_signal i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_price     (i_price),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_average   (o_average),
        .o_signal    (o_signal),
        .o_buy_total (o_buy_total),
        .o_sell_total(o_sell_total),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("sma_band_signal_tb failed");
        $finish;
    end

    // result side: random stall bursts, check every accepted word
    initial begin
        int stall;
        stall = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready)
                book.match_signal(o_average, o_signal, o_buy_total, o_sell_total);
            if (stall > 0) begin
                stall--;
                i_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 5) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic send_price(input logic [PRICE_BITS-1:0] price);
        i_valid <= 1'b1;
        i_price <= price;
        do @(posedge i_clk); while (!o_ready);
        book.take_price(price);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        book.note_write(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop sending and let every pending word come out
    task automatic settle();
        i_valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    function automatic logic [PRICE_BITS-1:0] near_price(input logic [PRICE_BITS-1:0] level);
        logic [63:0] span;
        logic [63:0] dev;
        logic [63:0] v;
        span = ({32'd0, level} >> $urandom_range(3, 8)) + 64'd3;
        dev  = {32'd0, $urandom_range(0, span[31:0])};
        if ($urandom_range(0, 1) == 0)
            v = (dev > level) ? 64'd0 : {32'd0, level} - dev;
        else
            v = {32'd0, level} + dev;
        if (v > 64'hFFFF_FFFF)
            v = 64'hFFFF_FFFF;
        return v[PRICE_BITS-1:0];
    endfunction

    function automatic logic [PRICE_BITS-1:0] pick_level();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(1, 500);
            1:       return $urandom_range(1000, 2000000);
            2:       return $urandom;
            default: return 32'hFFFF_FFFF - $urandom_range(0, 100000);
        endcase
    endfunction

    task automatic configure_phase(input int idx);
        logic [5:0]        len;
        logic [BAND_W-1:0] lo;
        logic [BAND_W-1:0] hi;
        case (idx)
            0: len = 6'd63;
            1: len = 6'd32;
            2: len = 6'd33;
            3: len = 6'd0;
            default: begin
                case ($urandom_range(0, 9))
                    0:       len = 6'd0;
                    1:       len = 6'($urandom_range(33, 63));
                    2:       len = 6'd32;
                    3:       len = 6'd1;
                    default: len = 6'($urandom_range(2, 31));
                endcase
            end
        endcase
        case ($urandom_range(0, 7))
            0: begin
                lo = 16'd0;
                hi = 16'hFFFF;
            end
            1: begin
                lo = 16'hFFFF;
                hi = 16'd0;
            end
            2: begin
                lo = 16'($urandom_range(0, 65535));
                hi = 16'($urandom_range(0, 65535));
            end
            default: begin
                lo = 16'(32768 - $urandom_range(0, 2000));
                hi = 16'(32768 + $urandom_range(0, 2000));
            end
        endcase
        write_reg(CFG_BAND_LOW, lo);
        write_reg(CFG_BAND_HIGH, hi);
        if ($urandom_range(0, 5) == 0)
            write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
        // sometimes keep the stream running across a band change
        if (idx < 4 || $urandom_range(0, 3) != 0)
            write_reg(CFG_WINDOW_LENGTH, {10'd0, len});
        settings++;
    endtask

    task automatic stream_phase(input int count);
        logic [PRICE_BITS-1:0] level;
        int                    n;
        int                    pick;
        level = pick_level();
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(0, 19);
            if ($urandom_range(0, 3) == 0)
                level = near_price(level);
            if (pick == 0)
                send_price($urandom);
            else if (pick == 1)
                send_price(($urandom_range(0, 1) == 0) ? '0 : '1);
            else
                send_price(near_price(level));
        end
    endtask

    initial begin
        int ph;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default window of five with extreme prices
        send_price('0);
        send_price('1);
        send_price('0);
        send_price('1);
        send_price('0);
        send_price(32'd100);
        send_price('1);
        settle();

        // zero window acts as one, inverted extreme bands
        write_reg(CFG_WINDOW_LENGTH, 16'd0);
        write_reg(CFG_BAND_LOW, 16'hFFFF);
        write_reg(CFG_BAND_HIGH, 16'd0);
        settings++;
        send_price('0);
        send_price(32'd1);
        send_price('1);
        settle();

        // zero bands sell on any nonzero price once the window is full
        write_reg(CFG_BAND_LOW, 16'd0);
        write_reg(CFG_WINDOW_LENGTH, 16'd2);
        settings++;
        send_price(32'd10);
        send_price(32'd10);
        send_price('0);
        settle();

        // unknown index is ignored, back to default bands
        write_reg(CFG_UNUSED, 16'hFFFF);
        write_reg(CFG_BAND_LOW, 16'd32440);
        write_reg(CFG_BAND_HIGH, 16'd33096);
        write_reg(CFG_WINDOW_LENGTH, 16'd1);
        settings++;
        send_price(32'd7);
        send_price(32'd7);
        settle();

        for (ph = 0; ph < PHASES; ph++) begin
            if (ph >= PHASES - 3)
                idle_on = 1'b0;
            configure_phase(ph);
            stream_phase(PHASE_WORDS);
            settle();
        end

        repeat (45) @(posedge i_clk);
        $display("sent %0d price words over %0d register settings", book.words_in, settings);
        $display("results seen: %0d buy, %0d sell, %0d hold",
                 book.buys_out, book.sells_out, book.holds_out);
        if (book.errors == 0 && book.pending() == 0) begin
            $display("sma_band_signal_tb passed");
        end else begin
            $display("%0d mismatches, %0d words missing", book.errors, book.pending());
            $display("sma_band_signal_tb failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/smabs_pkg.sv
design/smabs_ctrl.sv
design/smabs_dp.sv
design/sma_band_signal.sv
verif/sma_band_signal_tb.sv
